[hw/rtl/xd_pkg.sv]
// xd_pkg: shared opcode patterns, field codes and the raw instruction record
// used by the front decoder, the record queue and the back field formatter.
// Depends on nothing.
package xd_pkg;

  localparam logic [7:0] OpcMovRm  = 8'b10001000;
  localparam logic [7:0] OpcAddRm  = 8'b00000000;
  localparam logic [7:0] MaskFc    = 8'b11111100;
  localparam logic [7:0] OpcMovIrm = 8'b11000110;
  localparam logic [7:0] OpcMovIr  = 8'b10110000;
  localparam logic [7:0] OpcSubRm  = 8'b00101000;
  localparam logic [7:0] OpcCmpRm  = 8'b00111000;
  localparam logic [7:0] OpcGrpIrm = 8'b10000000;
  localparam logic [7:0] OpcJcc    = 8'b01110000;
  localparam logic [7:0] MaskF0    = 8'b11110000;
  localparam logic [7:0] MaskFe    = 8'b11111110;

  localparam logic [2:0] SubAdd = 3'd0;
  localparam logic [2:0] SubSub = 3'd5;
  localparam logic [2:0] SubCmp = 3'd7;
  localparam logic [1:0] ModMem0 = 2'd0;
  localparam logic [1:0] ModMem8 = 2'd1;
  localparam logic [1:0] ModMem16 = 2'd2;
  localparam logic [2:0] RmDirect = 3'd6;

  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    FORM_REG_RM  = 2'd0,
    FORM_IMM_REG = 2'd1,
    FORM_IMM_RM  = 2'd2,
    FORM_JUMP    = 2'd3
  } form_e;

  typedef enum logic [2:0] {
    OP_MOV   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_CMP   = 3'd3,
    OP_JCC   = 3'd4,
    OP_OTHER = 3'd5
  } op_e;

  typedef struct packed {
    logic  known;
    form_e form;
  } xd_class_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [7:0]  jbyte;
  } xd_raw_t;

  function automatic xd_class_t xd_classify(input logic [7:0] op);
    xd_class_t c;
    c.known = 1'b1;
    c.form  = FORM_REG_RM;
    if ((op & MaskFc) == OpcMovRm || (op & MaskFc) == OpcAddRm ||
        (op & MaskFc) == OpcSubRm || (op & MaskFc) == OpcCmpRm) begin
      c.form = FORM_REG_RM;
    end else if ((op & MaskF0) == OpcMovIr) begin
      c.form = FORM_IMM_REG;
    end else if ((op & MaskFe) == OpcMovIrm || (op & MaskFc) == OpcGrpIrm) begin
      c.form = FORM_IMM_RM;
    end else if ((op & MaskF0) == OpcJcc) begin
      c.form = FORM_JUMP;
    end else begin
      c.known = 1'b0;
    end
    return c;
  endfunction

  // number of displacement bytes a modrm byte calls for
  function automatic logic [1:0] xd_disp_bytes(input logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (m[7:6] == ModMem8) begin
      n = 2'd1;
    end else if (m[7:6] == ModMem16) begin
      n = 2'd2;
    end else if (m[7:6] == ModMem0 && m[2:0] == RmDirect) begin
      n = 2'd2;
    end
    return n;
  endfunction

  function automatic logic xd_imm_two(input logic [7:0] op);
    logic r;
    if ((op & MaskF0) == OpcMovIr) begin
      r = op[3];
    end else if ((op & MaskFe) == OpcMovIrm) begin
      r = op[0];
    end else begin
      r = op[0] & ~op[1];
    end
    return r;
  endfunction

  function automatic logic [15:0] xd_short_imm(input logic [7:0] op, input logic [7:0] lo);
    logic [15:0] r;
    r = {8'h00, lo};
    if ((op & MaskFc) == OpcGrpIrm && op[1:0] == 2'b11 && lo[7]) begin
      r = {8'hFF, lo};
    end
    return r;
  endfunction

endpackage

[hw/rtl/xd_front.sv]
// xd_front: byte-serial phase machine that collects opcode, modrm,
// displacement, immediate and jump offset bytes and emits one raw record per instruction.
// Depends on xd_pkg.
module xd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     code_byte_i,
  output logic           emit_o,
  output xd_pkg::xd_raw_t rec_o
);
  import xd_pkg::*;

  typedef enum logic [6:0] {
    PH_OPCODE = 7'b0000001,
    PH_MODRM  = 7'b0000010,
    PH_DISPLO = 7'b0000100,
    PH_DISPHI = 7'b0001000,
    PH_IMMLO  = 7'b0010000,
    PH_IMMHI  = 7'b0100000,
    PH_JUMP   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d;
  logic [7:0]  imml_q, imml_d;
  logic [15:0] imm_v;
  logic [7:0]  jb_v;
  logic        emit;
  xd_class_t   held_cls, new_cls;

  assign held_cls = xd_classify(opcode_q);
  assign new_cls  = xd_classify(code_byte_i);

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    modrm_d  = modrm_q;
    disp_d   = disp_q;
    imml_d   = imml_q;
    imm_v    = 16'h0000;
    jb_v     = 8'h00;
    emit     = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_MODRM: begin
          modrm_d = code_byte_i;
          if (xd_disp_bytes(code_byte_i) != 2'd0) begin
            phase_d = PH_DISPLO;
          end else if (held_cls.form == FORM_IMM_RM) begin
            phase_d = PH_IMMLO;
          end else begin
            phase_d = PH_OPCODE;
            emit    = 1'b1;
          end
        end
        PH_DISPLO: begin
          if (xd_disp_bytes(modrm_q) == 2'd1) begin
            disp_d = {{8{code_byte_i[7]}}, code_byte_i};
            if (held_cls.form == FORM_IMM_RM) begin
              phase_d = PH_IMMLO;
            end else begin
              phase_d = PH_OPCODE;
              emit    = 1'b1;
            end
          end else begin
            disp_d  = {8'h00, code_byte_i};
            phase_d = PH_DISPHI;
          end
        end
        PH_DISPHI: begin
          disp_d = {code_byte_i, disp_q[7:0]};
          if (held_cls.form == FORM_IMM_RM) begin
            phase_d = PH_IMMLO;
          end else begin
            phase_d = PH_OPCODE;
            emit    = 1'b1;
          end
        end
        PH_IMMLO: begin
          imml_d = code_byte_i;
          if (xd_imm_two(opcode_q)) begin
            phase_d = PH_IMMHI;
          end else begin
            phase_d = PH_OPCODE;
            emit    = 1'b1;
            imm_v   = xd_short_imm(opcode_q, code_byte_i);
          end
        end
        PH_IMMHI: begin
          phase_d = PH_OPCODE;
          emit    = 1'b1;
          imm_v   = {code_byte_i, imml_q};
        end
        PH_JUMP: begin
          phase_d = PH_OPCODE;
          emit    = 1'b1;
          jb_v    = code_byte_i;
        end
        default: begin
          phase_d = PH_OPCODE;
          if (new_cls.known) begin
            opcode_d = code_byte_i;
            modrm_d  = 8'h00;
            disp_d   = 16'h0000;
            imml_d   = 8'h00;
            if (new_cls.form == FORM_IMM_REG) begin
              phase_d = PH_IMMLO;
            end else if (new_cls.form == FORM_JUMP) begin
              phase_d = PH_JUMP;
            end else begin
              phase_d = PH_MODRM;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      opcode_q <= 8'h00;
      modrm_q  <= 8'h00;
      disp_q   <= 16'h0000;
      imml_q   <= 8'h00;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      modrm_q  <= modrm_d;
      disp_q   <= disp_d;
      imml_q   <= imml_d;
    end
  end

  assign emit_o       = emit;
  assign rec_o.opcode = opcode_q;
  assign rec_o.modrm  = modrm_d;
  assign rec_o.disp   = disp_d;
  assign rec_o.imm    = imm_v;
  assign rec_o.jbyte  = jb_v;

endmodule

[hw/rtl/xd_queue.sv]
// xd_queue: short register queue of raw instruction records between the
// front decoder and the back formatter.
// Depends on xd_pkg.
module xd_queue #(
  parameter int unsigned Depth = xd_pkg::QDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xd_pkg::xd_raw_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output xd_pkg::xd_raw_t data_o,
  output logic            empty_o
);
  import xd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  xd_raw_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/xd_back.sv]
// xd_back: turns a raw instruction record into decoded result fields and
// holds them in the output register until popped.
// Depends on xd_pkg.
module xd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_valid_i,
  input  xd_pkg::xd_raw_t rec_i,
  output logic            rec_take_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [2:0]      operation_o,
  output logic [1:0]      form_o,
  output logic            reg_is_destination_o,
  output logic            wide_o,
  output logic [2:0]      reg_field_o,
  output logic [1:0]      mode_field_o,
  output logic [2:0]      rm_field_o,
  output logic [15:0]     displacement_o,
  output logic [15:0]     immediate_o,
  output logic [3:0]      jump_condition_o,
  output logic signed [7:0] jump_offset_o
);
  import xd_pkg::*;

  logic        valid_q, valid_d, load;
  xd_class_t   cls;
  op_e         op_d;
  logic [2:0]  op_q;
  logic [1:0]  form_q;
  logic        dir_q, dir_d, wide_q, wide_d;
  logic [2:0]  reg_q, reg_d, rm_q, rm_d;
  logic [1:0]  mod_q, mod_d;
  logic [15:0] disp_q, disp_d, imm_q, imm_d;
  logic [3:0]  cond_q, cond_d;
  logic [7:0]  jofs_q, jofs_d;

  assign cls        = xd_classify(rec_i.opcode);
  assign load       = rec_valid_i & (~valid_q | pop_i);
  assign rec_take_o = load;

  always_comb begin
    op_d   = OP_MOV;
    dir_d  = 1'b0;
    wide_d = 1'b0;
    reg_d  = 3'd0;
    mod_d  = 2'd0;
    rm_d   = 3'd0;
    disp_d = 16'h0000;
    imm_d  = 16'h0000;
    cond_d = 4'd0;
    jofs_d = 8'h00;
    unique case (cls.form)
      FORM_REG_RM, FORM_IMM_RM: begin
        dir_d  = (cls.form == FORM_REG_RM) ? rec_i.opcode[1] : 1'b0;
        wide_d = rec_i.opcode[0];
        reg_d  = rec_i.modrm[5:3];
        mod_d  = rec_i.modrm[7:6];
        rm_d   = rec_i.modrm[2:0];
        disp_d = rec_i.disp;
        if (cls.form == FORM_REG_RM) begin
          if ((rec_i.opcode & MaskFc) == OpcMovRm) begin
            op_d = OP_MOV;
          end else if ((rec_i.opcode & MaskFc) == OpcSubRm) begin
            op_d = OP_SUB;
          end else if ((rec_i.opcode & MaskFc) == OpcCmpRm) begin
            op_d = OP_CMP;
          end else begin
            op_d = OP_ADD;
          end
        end else begin
          imm_d = rec_i.imm;
          if ((rec_i.opcode & MaskFe) == OpcMovIrm) begin
            op_d = OP_MOV;
          end else if (rec_i.modrm[5:3] == SubAdd) begin
            op_d = OP_ADD;
          end else if (rec_i.modrm[5:3] == SubSub) begin
            op_d = OP_SUB;
          end else if (rec_i.modrm[5:3] == SubCmp) begin
            op_d = OP_CMP;
          end else begin
            op_d = OP_OTHER;
          end
        end
      end
      FORM_IMM_REG: begin
        op_d   = OP_MOV;
        dir_d  = 1'b1;
        wide_d = rec_i.opcode[3];
        reg_d  = rec_i.opcode[2:0];
        imm_d  = rec_i.imm;
      end
      FORM_JUMP: begin
        op_d   = OP_JCC;
        cond_d = rec_i.opcode[3:0];
        jofs_d = rec_i.jbyte;
      end
      default: begin
        op_d = OP_MOV;
      end
    endcase
  end

  assign valid_d = load | (valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= op_d;
      form_q <= cls.form;
      dir_q  <= dir_d;
      wide_q <= wide_d;
      reg_q  <= reg_d;
      mod_q  <= mod_d;
      rm_q   <= rm_d;
      disp_q <= disp_d;
      imm_q  <= imm_d;
      cond_q <= cond_d;
      jofs_q <= jofs_d;
    end
  end

  assign empty_o              = ~valid_q;
  assign operation_o          = op_q;
  assign form_o               = form_q;
  assign reg_is_destination_o = dir_q;
  assign wide_o               = wide_q;
  assign reg_field_o          = reg_q;
  assign mode_field_o         = mod_q;
  assign rm_field_o           = rm_q;
  assign displacement_o       = disp_q;
  assign immediate_o          = imm_q;
  assign jump_condition_o     = cond_q;
  assign jump_offset_o        = signed'(jofs_q);

endmodule

[hw/rtl/x86_16bit_instruction_decoder.sv]
// x86_16bit_instruction_decoder: top level of the byte-serial 8086 subset
// decoder: front phase machine, record queue and back field formatter.
// Depends on xd_pkg, xd_front, xd_queue, xd_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | push / full        | code_byte_i
//   result   | empty / pop        | operation_o .. jump_offset_o
//
// one code byte accepted per cycle unless full is high; a result reaches the ports after the beat
// carrying the last byte of its instruction, via the queue write, then the output register load
// full rises only when the record queue is full, i.e. after results go unpopped
// reset clears the phase machine, the queue pointers and the output valid bit
module x86_16bit_instruction_decoder #(
  parameter int unsigned QueueDepth = xd_pkg::QDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        code_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        operation_o,
  output logic [1:0]        form_o,
  output logic              reg_is_destination_o,
  output logic              wide_o,
  output logic [2:0]        reg_field_o,
  output logic [1:0]        mode_field_o,
  output logic [2:0]        rm_field_o,
  output logic [15:0]       displacement_o,
  output logic [15:0]       immediate_o,
  output logic [3:0]        jump_condition_o,
  output logic signed [7:0] jump_offset_o
);
  import xd_pkg::*;

  logic    accept, emit, q_full, q_empty, q_pop;
  xd_raw_t front_rec, q_rec;

  assign full   = q_full;
  assign accept = push & ~q_full;

  xd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_byte_i (code_byte_i),
    .emit_o      (emit),
    .rec_o       (front_rec)
  );

  xd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rec),
    .empty_o (q_empty)
  );

  xd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rec_valid_i          (~q_empty),
    .rec_i                (q_rec),
    .rec_take_o           (q_pop),
    .pop_i                (pop),
    .empty_o              (empty),
    .operation_o          (operation_o),
    .form_o               (form_o),
    .reg_is_destination_o (reg_is_destination_o),
    .wide_o               (wide_o),
    .reg_field_o          (reg_field_o),
    .mode_field_o         (mode_field_o),
    .rm_field_o           (rm_field_o),
    .displacement_o       (displacement_o),
    .immediate_o          (immediate_o),
    .jump_condition_o     (jump_condition_o),
    .jump_offset_o        (jump_offset_o)
  );

  a_no_emit_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && q_full))
    else $error("front emitted a record into a full queue");

  a_back_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && empty) |=> !empty)
    else $error("waiting record not loaded into empty output register");

  a_jump_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && form_o == FORM_JUMP) |->
      (displacement_o == 16'h0000 && immediate_o == 16'h0000 && mode_field_o == 2'd0))
    else $error("jump result carries operand fields");

  a_imm_reg_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && form_o == FORM_IMM_REG) |->
      (reg_is_destination_o && rm_field_o == 3'd0 && jump_offset_o == 8'sd0))
    else $error("immediate-to-register result malformed");

endmodule

[tb/tb.sv]
// tb: self-checking bench for x86_16bit_instruction_decoder. A directed byte table with typed results and
// random instruction streams (some malformed) are run through a local predictor and compared per beat.
// Depends on xd_pkg and the decoder RTL.
module tb;
  import xd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 1900;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    op_e         operation;
    form_e       form;
    logic        reg_dest;
    logic        wide;
    logic [2:0]  reg_num;
    logic [1:0]  mode;
    logic [2:0]  rm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [3:0]  jcond;
    logic [7:0]  joffset;
  } decoded_t;

  typedef struct packed {
    logic [7:0] code;
    logic       has_typed;
    decoded_t   typed;
  } code_row_t;

  typedef enum logic [2:0] {
    AT_OPCODE, AT_MODRM, AT_DISP_LO, AT_DISP_HI, AT_IMM_LO, AT_IMM_HI, AT_JUMP_OFFSET
  } decode_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  code_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  operation;
  logic [1:0]  form;
  logic        reg_is_destination;
  logic        wide;
  logic [2:0]  reg_field;
  logic [1:0]  mode_field;
  logic [2:0]  rm_field;
  logic [15:0] displacement;
  logic [15:0] immediate;
  logic [3:0]  jump_condition;
  logic signed [7:0] jump_offset;

  x86_16bit_instruction_decoder u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .code_byte_i          (code_byte),
    .empty                (empty),
    .pop                  (pop),
    .operation_o          (operation),
    .form_o               (form),
    .reg_is_destination_o (reg_is_destination),
    .wide_o               (wide),
    .reg_field_o          (reg_field),
    .mode_field_o         (mode_field),
    .rm_field_o           (rm_field),
    .displacement_o       (displacement),
    .immediate_o          (immediate),
    .jump_condition_o     (jump_condition),
    .jump_offset_o        (jump_offset)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  decode_phase_e decode_phase = AT_OPCODE;
  logic [7:0]    held_op = 8'h00;
  logic [7:0]    held_modrm = 8'h00;
  logic [15:0]   held_disp = 16'h0000;
  logic [7:0]    held_imm_lo = 8'h00;

  decoded_t pending_decodes[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       sent_bytes = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  code_row_t code_rows[27];

  function automatic bit opcode_form(input logic [7:0] op, output form_e f);
    f = FORM_REG_RM;
    if ((op & MaskFc) == OpcMovRm || (op & MaskFc) == OpcAddRm ||
        (op & MaskFc) == OpcSubRm || (op & MaskFc) == OpcCmpRm) begin
      f = FORM_REG_RM;
    end else if ((op & MaskF0) == OpcMovIr) begin
      f = FORM_IMM_REG;
    end else if ((op & MaskFe) == OpcMovIrm || (op & MaskFc) == OpcGrpIrm) begin
      f = FORM_IMM_RM;
    end else if ((op & MaskF0) == OpcJcc) begin
      f = FORM_JUMP;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int disp_count(input logic [7:0] m);
    if (m[7:6] == ModMem8) return 1;
    if (m[7:6] == ModMem16) return 2;
    if (m[7:6] == ModMem0 && m[2:0] == RmDirect) return 2;
    return 0;
  endfunction

  function automatic bit imm_is_wide(input logic [7:0] op);
    if ((op & MaskF0) == OpcMovIr) return op[3];
    if ((op & MaskFe) == OpcMovIrm) return op[0];
    return op[0] & ~op[1];
  endfunction

  function automatic decoded_t pack_decode(input logic [15:0] imm, input logic [7:0] jbyte);
    decoded_t r;
    form_e    f;
    r = '0;
    void'(opcode_form(held_op, f));
    r.form = f;
    case (f)
      FORM_REG_RM, FORM_IMM_RM: begin
        r.wide    = held_op[0];
        r.reg_num = held_modrm[5:3];
        r.mode    = held_modrm[7:6];
        r.rm      = held_modrm[2:0];
        r.disp    = held_disp;
        if (f == FORM_REG_RM) begin
          r.reg_dest = held_op[1];
          if ((held_op & MaskFc) == OpcMovRm) r.operation = OP_MOV;
          else if ((held_op & MaskFc) == OpcSubRm) r.operation = OP_SUB;
          else if ((held_op & MaskFc) == OpcCmpRm) r.operation = OP_CMP;
          else r.operation = OP_ADD;
        end else begin
          r.imm = imm;
          if ((held_op & MaskFe) == OpcMovIrm) r.operation = OP_MOV;
          else if (held_modrm[5:3] == SubAdd) r.operation = OP_ADD;
          else if (held_modrm[5:3] == SubSub) r.operation = OP_SUB;
          else if (held_modrm[5:3] == SubCmp) r.operation = OP_CMP;
          else r.operation = OP_OTHER;
        end
      end
      FORM_IMM_REG: begin
        r.operation = OP_MOV;
        r.reg_dest  = 1'b1;
        r.wide      = held_op[3];
        r.reg_num   = held_op[2:0];
        r.imm       = imm;
      end
      default: begin
        r.operation = OP_JCC;
        r.jcond     = held_op[3:0];
        r.joffset   = jbyte;
      end
    endcase
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, output bit got, output decoded_t r);
    form_e f;
    bit    disp_done;
    got = 1'b0;
    r = '0;
    disp_done = 1'b0;
    void'(opcode_form(held_op, f));
    case (decode_phase)
      AT_MODRM: begin
        held_modrm = b;
        if (disp_count(b) != 0) begin
          decode_phase = AT_DISP_LO;
        end else begin
          disp_done = 1'b1;
        end
      end
      AT_DISP_LO: begin
        if (disp_count(held_modrm) == 1) begin
          held_disp = {{8{b[7]}}, b};
          disp_done = 1'b1;
        end else begin
          held_disp = {8'h00, b};
          decode_phase = AT_DISP_HI;
        end
      end
      AT_DISP_HI: begin
        held_disp[15:8] = b;
        disp_done = 1'b1;
      end
      AT_IMM_LO: begin
        held_imm_lo = b;
        if (imm_is_wide(held_op)) begin
          decode_phase = AT_IMM_HI;
        end else begin
          decode_phase = AT_OPCODE;
          got = 1'b1;
          if ((held_op & MaskFc) == OpcGrpIrm && held_op[1:0] == 2'b11) begin
            r = pack_decode({{8{b[7]}}, b}, 8'h00);
          end else begin
            r = pack_decode({8'h00, b}, 8'h00);
          end
        end
      end
      AT_IMM_HI: begin
        decode_phase = AT_OPCODE;
        got = 1'b1;
        r = pack_decode({b, held_imm_lo}, 8'h00);
      end
      AT_JUMP_OFFSET: begin
        decode_phase = AT_OPCODE;
        got = 1'b1;
        r = pack_decode(16'h0000, b);
      end
      default: begin
        decode_phase = AT_OPCODE;
        if (opcode_form(b, f)) begin
          held_op = b;
          held_modrm = 8'h00;
          held_disp = 16'h0000;
          held_imm_lo = 8'h00;
          if (f == FORM_IMM_REG) decode_phase = AT_IMM_LO;
          else if (f == FORM_JUMP) decode_phase = AT_JUMP_OFFSET;
          else decode_phase = AT_MODRM;
        end
      end
    endcase
    if (disp_done) begin
      if (f == FORM_IMM_RM) begin
        decode_phase = AT_IMM_LO;
      end else begin
        decode_phase = AT_OPCODE;
        got = 1'b1;
        r = pack_decode(16'h0000, 8'h00);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit has_typed, input decoded_t typed);
    bit       got;
    decoded_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    code_byte <= b;
    do @(posedge clk_i); while (full);
    decode_byte(b, got, r);
    if (got) begin
      pending_decodes.push_back(has_typed ? typed : r);
    end else if (has_typed) begin
      $error("byte %h completed no instruction", b);
      mismatch_count++;
    end
  endtask

  task automatic send_random_instruction();
    logic [7:0] op;
    logic [7:0] modrm;
    logic [7:0] stream[$];
    form_e      f;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      send_byte(8'($urandom), 1'b0, '0);
      sent_bytes++;
      return;
    end
    if (kind >= 88) begin
      // opcode the block skips
      do op = 8'($urandom); while (opcode_form(op, f));
      send_byte(op, 1'b0, '0);
      sent_bytes++;
      return;
    end
    if (kind < 25) begin
      case ($urandom_range(0, 3))
        0: op = OpcMovRm;
        1: op = OpcAddRm;
        2: op = OpcSubRm;
        default: op = OpcCmpRm;
      endcase
      op = op | 8'($urandom_range(0, 3));
    end else if (kind < 40) begin
      op = OpcMovIr | 8'($urandom_range(0, 15));
    end else if (kind < 55) begin
      op = OpcMovIrm | 8'($urandom_range(0, 1));
    end else if (kind < 75) begin
      op = OpcGrpIrm | 8'($urandom_range(0, 3));
    end else begin
      op = OpcJcc | 8'($urandom_range(0, 15));
    end
    void'(opcode_form(op, f));
    stream.push_back(op);
    if (f == FORM_REG_RM || f == FORM_IMM_RM) begin
      modrm = 8'($urandom);
      if ($urandom_range(0, 4) == 0) modrm = {ModMem0, modrm[5:3], RmDirect};
      stream.push_back(modrm);
      repeat (disp_count(modrm)) stream.push_back(8'($urandom));
    end
    if (f == FORM_IMM_RM || f == FORM_IMM_REG) begin
      repeat (imm_is_wide(op) ? 2 : 1) stream.push_back(8'($urandom));
    end
    if (f == FORM_JUMP) stream.push_back(8'($urandom));
    // truncated instruction now and then
    if ($urandom_range(0, 19) == 0) void'(stream.pop_back());
    foreach (stream[i]) send_byte(stream[i], 1'b0, '0);
    sent_bytes += stream.size();
  endtask

  task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      $error("%s expected %0h got %0h", name, exp, act);
      mismatch_count++;
    end
  endtask

  task automatic check_beat();
    decoded_t e;
    if (pending_decodes.size() == 0) begin
      $error("decoded beat with nothing expected");
      mismatch_count++;
      return;
    end
    e = pending_decodes.pop_front();
    check_field("operation", 16'(e.operation), 16'(operation));
    check_field("form", 16'(e.form), 16'(form));
    check_field("reg_is_destination", 16'(e.reg_dest), 16'(reg_is_destination));
    check_field("wide", 16'(e.wide), 16'(wide));
    check_field("reg_field", 16'(e.reg_num), 16'(reg_field));
    check_field("mode_field", 16'(e.mode), 16'(mode_field));
    check_field("rm_field", 16'(e.rm), 16'(rm_field));
    check_field("displacement", e.disp, displacement);
    check_field("immediate", e.imm, immediate);
    check_field("jump_condition", 16'(e.jcond), 16'(jump_condition));
    check_field("jump_offset", 16'(e.joffset), 16'($unsigned(jump_offset)));
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_beat();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("x86_16bit_instruction_decoder verification failed");
    $finish;
  end

  initial begin
    code_rows = '{
      '{8'h8B, 1'b0, '0},
      '{8'hFF, 1'b1, '{OP_MOV, FORM_REG_RM, 1'b1, 1'b1, 3'd7, 2'd3, 3'd7,
                       16'h0000, 16'h0000, 4'h0, 8'h00}},
      '{8'h02, 1'b0, '0},
      '{8'h00, 1'b1, '{OP_ADD, FORM_REG_RM, 1'b1, 1'b0, 3'd0, 2'd0, 3'd0,
                       16'h0000, 16'h0000, 4'h0, 8'h00}},
      '{8'hFF, 1'b0, '0},
      '{8'h29, 1'b0, '0},
      '{8'h06, 1'b0, '0},
      '{8'h34, 1'b0, '0},
      '{8'h12, 1'b1, '{OP_SUB, FORM_REG_RM, 1'b0, 1'b1, 3'd0, 2'd0, 3'd6,
                       16'h1234, 16'h0000, 4'h0, 8'h00}},
      '{8'h38, 1'b0, '0},
      '{8'h45, 1'b0, '0},
      '{8'h80, 1'b1, '{OP_CMP, FORM_REG_RM, 1'b0, 1'b0, 3'd0, 2'd1, 3'd5,
                       16'hFF80, 16'h0000, 4'h0, 8'h00}},
      '{8'hBF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, '{OP_MOV, FORM_IMM_REG, 1'b1, 1'b1, 3'd7, 2'd0, 3'd0,
                       16'h0000, 16'hFFFF, 4'h0, 8'h00}},
      '{8'hC6, 1'b0, '0},
      '{8'h38, 1'b0, '0},
      '{8'h7F, 1'b1, '{OP_MOV, FORM_IMM_RM, 1'b0, 1'b0, 3'd7, 2'd0, 3'd0,
                       16'h0000, 16'h007F, 4'h0, 8'h00}},
      '{8'h83, 1'b0, '0},
      '{8'hE8, 1'b0, '0},
      '{8'h80, 1'b1, '{OP_SUB, FORM_IMM_RM, 1'b0, 1'b1, 3'd5, 2'd3, 3'd0,
                       16'h0000, 16'hFF80, 4'h0, 8'h00}},
      '{8'h81, 1'b0, '0},
      '{8'hD1, 1'b0, '0},
      '{8'h34, 1'b0, '0},
      '{8'h12, 1'b1, '{OP_OTHER, FORM_IMM_RM, 1'b0, 1'b1, 3'd2, 2'd3, 3'd1,
                       16'h0000, 16'h1234, 4'h0, 8'h00}},
      '{8'h7F, 1'b0, '0},
      '{8'h80, 1'b1, '{OP_JCC, FORM_JUMP, 1'b0, 1'b0, 3'd0, 2'd0, 3'd0,
                       16'h0000, 16'h0000, 4'hF, 8'h80}}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 34;
    recv_idle = 79;
    foreach (code_rows[i]) send_byte(code_rows[i].code, code_rows[i].has_typed,
                                     code_rows[i].typed);
    for (int stage = 0; stage < 3; stage++) begin
      send_idle = (stage == 0) ? 34 : (stage == 1) ? 79 : 0;
      recv_idle = (stage == 0) ? 79 : (stage == 1) ? 34 : 0;
      if (stage == 2) hold_req = 1'b1;
      sent_bytes = 0;
      while (sent_bytes < RandomBytes / 3) send_random_instruction();
    end
    push <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("x86_16bit_instruction_decoder verification clean");
    end else begin
      $display("x86_16bit_instruction_decoder verification failed");
    end
    $finish;
  end

endmodule
